### rtl/star_wildcard_name_matcher_assert.svh
// Assertion macros used by the star wildcard name matcher checker.
// Each macro expands to one labeled concurrent assertion with a reset disable.
`ifndef STAR_WILDCARD_NAME_MATCHER_ASSERT_SVH
`define STAR_WILDCARD_NAME_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while rst is high.
`define SWNM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swnm assertion failed");

// Next-cycle implication, disabled while rst is high.
`define SWNM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swnm assertion failed");

`endif

### rtl/swnm_pkg.sv
// Shared types and constants for the star wildcard name matcher.
// No dependencies; used by the matcher top level, the checker and the bench.
`timescale 1ns / 1ps
`default_nettype none

package swnm_pkg;

   // request kinds carried in tuser
   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_NAME   = 2'd2
   } op_type;

   localparam logic [7:0] STAR_CHAR = 8'd42;
   localparam logic [7:0] DOT_CHAR  = 8'd46;

endpackage

`default_nettype wire

### rtl/star_wildcard_name_matcher.sv
// Top level of the star wildcard name matcher: request stage, pattern store,
// position set update and response register. Depends on swnm_pkg, swnm_star_close.
//
// Usage:
//   Requests arrive on req_* (tvalid/tready). req_tuser selects the kind:
//   clear pattern, append pattern byte, or name byte; req_tdata is the byte
//   and req_tlast flags the last byte of a name. '*' in the pattern matches
//   any run of bytes, including none; the names "." and ".." never match.
//   One response leaves on rsp_* for each name byte that carries tlast:
//   bit 0 is the match flag, bit 1 the sticky pattern-overflow flag.
//   A name's final byte is held in the request register and then written to
//   the response register, which raises rsp_tvalid. Throughput: one request
//   per cycle unless a name-ending request waits on a stalled response; the
//   whole position-set update is one pass through the star closure network
//   between those two registers.
//   A stalled response holds; the request register keeps taking requests
//   that produce no response, and a name-ending request waits in it with
//   req_tready low until the response register frees.
//   Reset clears the pattern (length zero), the overflow flag and the name
//   tracking; the pattern bytes themselves are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module star_wildcard_name_matcher #(
   parameter int unsigned PATTERN_MAX = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic [1:0]  req_tuser,   // [1:0] operation
   input  logic        req_tlast,   // name_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] matched, [1] pattern_too_long, [7:2] zero
);

   localparam int unsigned POS_W = PATTERN_MAX + 1;
   localparam int unsigned LEN_W = $clog2(POS_W);

   // request stage
   logic                 stage_valid_ff, stage_valid_in;
   swnm_pkg::op_type     stage_op_ff;
   logic [7:0]           stage_char_ff;
   logic                 stage_end_ff;

   // pattern state
   logic [7:0]           store_ff [PATTERN_MAX];
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 ovf_ff, ovf_in;
   logic [POS_W-1:0]     lead_ff, lead_in;

   // name tracking
   logic [POS_W-1:0]     active_ff, active_in;
   logic [1:0]           cnt_ff, cnt_in;
   logic                 dots_ff, dots_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_match_ff, rsp_match_in;
   logic                 rsp_ovf_ff;

   logic                 req_fire;
   logic                 produces;
   logic                 go;
   logic                 do_append;
   logic                 has_room;
   logic                 char_is_star;
   logic [PATTERN_MAX-1:0] star_vec;
   logic [POS_W-1:0]     step_vec;
   logic [POS_W-1:0]     closed_vec;

   // handshake
   assign req_fire   = req_tvalid && req_tready;
   assign produces   = stage_valid_ff && (stage_op_ff == swnm_pkg::OP_NAME) && stage_end_ff;
   assign go         = stage_valid_ff && (!produces || !rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || go;

   assign has_room     = len_ff < LEN_W'(PATTERN_MAX);
   assign do_append    = go && (stage_op_ff == swnm_pkg::OP_APPEND) && has_room;
   assign char_is_star = stage_char_ff == swnm_pkg::STAR_CHAR;

   // per-position star flags and one-byte step over the active set
   always_comb begin
      step_vec = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         star_vec[i] = (LEN_W'(i) < len_ff) && (store_ff[i] == swnm_pkg::STAR_CHAR);
         if (active_ff[i] && star_vec[i]) begin
            step_vec[i] = 1'b1;
         end
         if (active_ff[i] && (LEN_W'(i) < len_ff) && !star_vec[i] &&
             (store_ff[i] == stage_char_ff)) begin
            step_vec[i+1] = 1'b1;
         end
      end
   end

   swnm_star_close #(
      .WIDTH (POS_W)
   ) u_close (
      .set_i    (step_vec),
      .star_i   (star_vec),
      .closed_o (closed_vec)
   );

   // next-state selection
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
      end else if (go) begin
         stage_valid_in = 1'b0;
      end

      len_in       = len_ff;
      ovf_in       = ovf_ff;
      lead_in      = lead_ff;
      active_in    = active_ff;
      cnt_in       = cnt_ff;
      dots_in      = dots_ff;
      rsp_match_in = 1'b0;

      if (go) begin
         case (stage_op_ff)
            swnm_pkg::OP_CLEAR: begin
               len_in    = '0;
               ovf_in    = 1'b0;
               lead_in   = POS_W'(1);
               active_in = POS_W'(1);
               cnt_in    = 2'd0;
               dots_in   = 1'b1;
            end
            swnm_pkg::OP_APPEND: begin
               if (has_room) begin
                  len_in = len_ff + LEN_W'(1);
                  // leading-star closure of the start position grows by one
                  for (int j = 1; j < POS_W; j++) begin
                     if ((len_ff == LEN_W'(j - 1)) && lead_ff[j-1] && char_is_star) begin
                        lead_in[j] = 1'b1;
                     end
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               active_in = has_room ? lead_in : lead_ff;
               cnt_in    = 2'd0;
               dots_in   = 1'b1;
            end
            swnm_pkg::OP_NAME: begin
               cnt_in  = (cnt_ff == 2'd3) ? 2'd3 : cnt_ff + 2'd1;
               dots_in = dots_ff && (stage_char_ff == swnm_pkg::DOT_CHAR);
               rsp_match_in = closed_vec[len_ff] && !(dots_in && (cnt_in != 2'd3));
               if (stage_end_ff) begin
                  active_in = lead_ff;
                  cnt_in    = 2'd0;
                  dots_in   = 1'b1;
               end else begin
                  active_in = closed_vec;
               end
            end
            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (go && produces) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         len_ff         <= '0;
         ovf_ff         <= 1'b0;
         lead_ff        <= POS_W'(1);
         active_ff      <= POS_W'(1);
         cnt_ff         <= 2'd0;
         dots_ff        <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         len_ff         <= len_in;
         ovf_ff         <= ovf_in;
         lead_ff        <= lead_in;
         active_ff      <= active_in;
         cnt_ff         <= cnt_in;
         dots_ff        <= dots_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_op_ff   <= swnm_pkg::op_type'(req_tuser);
         stage_char_ff <= req_tdata;
         stage_end_ff  <= req_tlast;
      end
      if (go && produces) begin
         rsp_match_ff <= rsp_match_in;
         rsp_ovf_ff   <= ovf_ff;
      end
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (do_append && (len_ff == LEN_W'(i))) begin
            store_ff[i] <= stage_char_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_ovf_ff, rsp_match_ff};

endmodule

`default_nettype wire

### rtl/swnm_star_close.sv
// Star closure network: marks every position reachable through a run of stars.
// Parallel-prefix (log depth) form of the carry-like propagation. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swnm_star_close #(
   parameter int unsigned WIDTH = 33
) (
   input  logic [WIDTH-1:0] set_i,
   input  logic [WIDTH-2:0] star_i,
   output logic [WIDTH-1:0] closed_o
);

   localparam int unsigned LEVELS = $clog2(WIDTH);

   // bit j is reached from j-1 when position j-1 holds a star
   always_comb begin
      logic [WIDTH-1:0] gen;
      logic [WIDTH-1:0] prop;
      logic [WIDTH-1:0] gen_nx;
      logic [WIDTH-1:0] prop_nx;
      gen  = set_i;
      prop = {star_i, 1'b0};
      for (int lv = 0; lv < LEVELS; lv++) begin
         gen_nx  = gen;
         prop_nx = prop;
         for (int j = 0; j < WIDTH; j++) begin
            if (j >= (1 << lv)) begin
               gen_nx[j]  = gen[j] | (prop[j] & gen[j - (1 << lv)]);
               prop_nx[j] = prop[j] & prop[j - (1 << lv)];
            end
         end
         gen  = gen_nx;
         prop = prop_nx;
      end
      closed_o = gen;
   end

endmodule

`default_nettype wire

### rtl/swnm_checker.sv
// Port-level checker for the star wildcard name matcher, bound to the top level.
// Depends on swnm_pkg and star_wildcard_name_matcher_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "star_wildcard_name_matcher_assert.svh"

module swnm_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_tvalid,
   input wire logic       req_tready,
   input wire logic [1:0] req_tuser,
   input wire logic       req_tlast,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   logic name_end_fire;

   assign name_end_fire = req_tvalid && req_tready && req_tlast &&
                          (req_tuser == swnm_pkg::OP_NAME);

   // no response may be pending right after reset
   `SWNM_ASSERT_NEXT(a_rsp_idle_after_reset, clock, 1'b0, reset, !rsp_tvalid)

   // a fresh response must be preceded by an accepted name-ending request
   `SWNM_ASSERT_IMPL(a_rsp_latency, clock, reset, $rose(rsp_tvalid), $past(name_end_fire, 2))

   // requests are refused only while a response is stalled
   `SWNM_ASSERT_IMPL(a_backpressure_cause, clock, reset, !req_tready,
                     rsp_tvalid && !rsp_tready)

   // a stalled response holds its data
   `SWNM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata))

endmodule

bind star_wildcard_name_matcher swnm_checker u_swnm_checker (.*);

`default_nettype wire

### bench/star_wildcard_name_matcher_tb.sv
// Self-checking bench for star_wildcard_name_matcher: a directed table, then random patterns
// and names, with each response compared against an in-bench bit-parallel matcher or a typed-in row.
// Depends on swnm_pkg and the matcher RTL.
`timescale 1ns / 1ps

module star_wildcard_name_matcher_tb;

   localparam int unsigned PAT_MAX      = 32;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam int unsigned RANDOM_ITEMS = 1450;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned IDLE_PCT     = 34;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] character
   logic [1:0] req_tuser  = 2'd0;   // [1:0] operation
   logic       req_tlast  = 1'b0;   // name_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] matched, [1] pattern_too_long, [7:2] zero

   star_wildcard_name_matcher #(
      .PATTERN_MAX(PAT_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Matcher model: pattern bytes, live position set, name tracking
   // ---------------------------------------------------------------
   logic [7:0]       pat_bytes [PAT_MAX];
   int unsigned      pat_len    = 0;
   logic [PAT_MAX:0] live_set   = (PAT_MAX+1)'(1);
   int unsigned      name_count = 0;
   bit               all_dots   = 1'b1;
   bit               long_flag  = 1'b0;

   logic [7:0]  verdict_q [$];   // expected response bytes, oldest first
   int unsigned mismatches  = 0;
   int unsigned sent        = 0; // random requests sent, ignored kinds excluded
   bit          steady_flow = 1'b0;
   logic [7:0]  loaded_pattern [$]; // pattern as the stimulus built it

   function automatic void restart_name();
      live_set   = (PAT_MAX+1)'(1);
      name_count = 0;
      all_dots   = 1'b1;
   endfunction

   // a live star also makes the position after it live; ascending order chains stars
   function automatic logic [PAT_MAX:0] close_stars(input logic [PAT_MAX:0] s);
      for (int i = 0; i < pat_len; i++)
         if (s[i] && pat_bytes[i] == swnm_pkg::STAR_CHAR) s[i+1] = 1'b1;
      return s;
   endfunction

   function automatic void match_step(input logic [1:0] op, input logic [7:0] ch,
                                      input logic last, output bit produced,
                                      output logic [7:0] verdict);
      logic [PAT_MAX:0] s;
      logic [PAT_MAX:0] nxt;
      bit               dot_name;
      bit               hit;
      produced = 1'b0;
      verdict  = 8'h00;
      case (op)
         swnm_pkg::OP_CLEAR: begin
            pat_len   = 0;
            long_flag = 1'b0;
            restart_name();
         end
         swnm_pkg::OP_APPEND: begin
            if (pat_len < PAT_MAX) begin
               pat_bytes[pat_len] = ch;
               pat_len++;
            end else begin
               long_flag = 1'b1;
            end
            restart_name();
         end
         swnm_pkg::OP_NAME: begin
            s   = close_stars(live_set);
            nxt = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (s[i]) begin
                  if (pat_bytes[i] == swnm_pkg::STAR_CHAR) nxt[i] = 1'b1;
                  else if (pat_bytes[i] == ch) nxt[i+1] = 1'b1;
               end
            end
            live_set = close_stars(nxt);
            if (name_count < 3) name_count++;
            if (ch != swnm_pkg::DOT_CHAR) all_dots = 1'b0;
            if (last) begin
               // "." and ".." never match
               dot_name = all_dots && name_count <= 2;
               hit      = live_set[pat_len];
               verdict  = {6'b0, long_flag, hit && !dot_name};
               produced = 1'b1;
               restart_name();
            end
         end
         default: ;  // unused kind: no effect
      endcase
   endfunction

   // ---------------------------------------------------------------
   // Response check
   // ---------------------------------------------------------------
   function automatic void note_mismatch(input string what, input logic [7:0] want,
                                         input logic [7:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s: expected %0h, got %0h at %0t ns", what, want, got, $time);
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_q.size() == 0) begin
            note_mismatch("unexpected response", 8'h00, rsp_tdata);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_tdata[0] !== want[0])
               note_mismatch("matched", {7'b0, want[0]}, {7'b0, rsp_tdata[0]});
            if (rsp_tdata[1] !== want[1])
               note_mismatch("pattern_too_long", {7'b0, want[1]}, {7'b0, rsp_tdata[1]});
            if (rsp_tdata[7:2] !== 6'b0)
               note_mismatch("padding", 8'h00, {2'b0, rsp_tdata[7:2]});
         end
      end
   end

   // receiver stalls, except in the steady stretch
   always @(negedge clock)
      rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);

   // ---------------------------------------------------------------
   // Request driver: called at a falling edge, returns at a falling edge
   // ---------------------------------------------------------------
   task automatic send_req(input logic [1:0] op, input logic [7:0] ch, input logic last,
                           input bit fixed, input logic [7:0] fixed_verdict);
      bit         produced;
      logic [7:0] verdict;
      if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      match_step(op, ch, last, produced, verdict);
      if (produced) verdict_q.push_back(fixed ? fixed_verdict : verdict);
      @(negedge clock);
   endtask

   task automatic send_plain(input logic [1:0] op, input logic [7:0] ch, input logic last);
      send_req(op, ch, last, 1'b0, 8'h00);
      if (op != OP_UNUSED) sent++;
      steady_flow = (sent >= 600 && sent < 850);
   endtask

   // ---------------------------------------------------------------
   // Directed table
   // ---------------------------------------------------------------
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] ch;
      logic       last;
      logic       fixed;       // expectation typed in below
      logic       want_match;
      logic       want_long;
   } dir_row_type;

   dir_row_type dir_rows [0:25] = '{
      // empty pattern right after reset: nothing matches
      '{swnm_pkg::OP_NAME,   "a",                 1'b1, 1'b1, 1'b0, 1'b0},
      // unused kind is ignored
      '{OP_UNUSED,           8'hFF,               1'b1, 1'b0, 1'b0, 1'b0},
      // pattern "*", name_end flag on an append is ignored
      '{swnm_pkg::OP_APPEND, swnm_pkg::STAR_CHAR, 1'b1, 1'b0, 1'b0, 1'b0},
      // "." and ".." refused even by "*"
      '{swnm_pkg::OP_NAME,   swnm_pkg::DOT_CHAR,  1'b1, 1'b1, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   swnm_pkg::DOT_CHAR,  1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   swnm_pkg::DOT_CHAR,  1'b1, 1'b1, 1'b0, 1'b0},
      // "..." is an ordinary name
      '{swnm_pkg::OP_NAME,   swnm_pkg::DOT_CHAR,  1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   swnm_pkg::DOT_CHAR,  1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   swnm_pkg::DOT_CHAR,  1'b1, 1'b0, 1'b0, 1'b0},
      // byte extremes
      '{swnm_pkg::OP_NAME,   8'hFF,               1'b1, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   8'h00,               1'b1, 1'b0, 1'b0, 1'b0},
      // pattern "a*<FF>"
      '{swnm_pkg::OP_CLEAR,  8'h00,               1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_APPEND, "a",                 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_APPEND, swnm_pkg::STAR_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_APPEND, 8'hFF,               1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   "a",                 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   8'hFF,               1'b1, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   "a",                 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   "b",                 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   "c",                 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   8'hFF,               1'b1, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   "b",                 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   8'hFF,               1'b1, 1'b0, 1'b0, 1'b0},
      // pattern change mid-name restarts the name
      '{swnm_pkg::OP_NAME,   "a",                 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_APPEND, swnm_pkg::STAR_CHAR, 1'b0, 1'b0, 1'b0, 1'b0},
      '{swnm_pkg::OP_NAME,   "x",                 1'b1, 1'b0, 1'b0, 1'b0}
   };

   // ---------------------------------------------------------------
   // Random stimulus: patterns rich in stars, names mostly built to fit them
   // ---------------------------------------------------------------
   function automatic logic [7:0] pattern_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return swnm_pkg::STAR_CHAR;
      if (r < 50) return "a";
      if (r < 65) return "b";
      if (r < 75) return swnm_pkg::DOT_CHAR;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] name_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return "a";
      if (r < 60) return "b";
      if (r < 75) return swnm_pkg::DOT_CHAR;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_episode();
      logic [7:0] name_q [$];
      logic [7:0] ch;
      int         plen;
      int         r;
      int         run;
      if ($urandom_range(0, 99) < 85) begin
         send_plain(swnm_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         loaded_pattern.delete();
      end
      // mostly short patterns, a few that overflow the store
      r = $urandom_range(0, 99);
      if (r < 5) plen = 0;
      else if (r < 92) plen = $urandom_range(1, 8);
      else plen = $urandom_range(PAT_MAX - 2, PAT_MAX + 8);
      repeat (plen) begin
         ch = pattern_char();
         loaded_pattern.push_back(ch);
         send_plain(swnm_pkg::OP_APPEND, ch, $urandom_range(0, 9) == 0);
      end
      repeat ($urandom_range(1, 6)) begin
         name_q.delete();
         r = $urandom_range(0, 99);
         if (r < 55) begin
            // expand each star to a short run, sometimes corrupt one byte
            foreach (loaded_pattern[i]) begin
               if (loaded_pattern[i] == swnm_pkg::STAR_CHAR) begin
                  run = $urandom_range(0, 3);
                  repeat (run) name_q.push_back(name_char());
               end else begin
                  name_q.push_back(loaded_pattern[i]);
               end
            end
            if (name_q.size() != 0 && $urandom_range(0, 4) == 0)
               name_q[$urandom_range(0, name_q.size() - 1)] = name_char();
         end else if (r < 75) begin
            repeat ($urandom_range(1, 6)) name_q.push_back(name_char());
         end else if (r < 85) begin
            repeat ($urandom_range(1, 3)) name_q.push_back(swnm_pkg::DOT_CHAR);
         end else begin
            repeat ($urandom_range(1, 4)) name_q.push_back(8'($urandom_range(0, 255)));
         end
         if (name_q.size() == 0) name_q.push_back(name_char());
         foreach (name_q[i]) begin
            // noise inside a name: ignored kinds and pattern changes
            if (i != 0 && $urandom_range(0, 99) < 2)
               send_plain(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            if (i != 0 && $urandom_range(0, 99) < 1) begin
               ch = pattern_char();
               loaded_pattern.push_back(ch);
               send_plain(swnm_pkg::OP_APPEND, ch, 1'b0);
            end
            send_plain(swnm_pkg::OP_NAME, name_q[i], i == name_q.size() - 1);
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[k])
         send_req(dir_rows[k].op, dir_rows[k].ch, dir_rows[k].last, dir_rows[k].fixed,
                  {6'b0, dir_rows[k].want_long, dir_rows[k].want_match});
      while (sent < RANDOM_ITEMS) random_episode();
      req_tvalid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### star_wildcard_name_matcher.f
+incdir+rtl
rtl/swnm_pkg.sv
rtl/swnm_star_close.sv
rtl/star_wildcard_name_matcher.sv
rtl/swnm_checker.sv
bench/star_wildcard_name_matcher_tb.sv
